FILE: design/physical_page_bitmap_allocator_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef PHYSICAL_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PHYSICAL_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PPBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define PPBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ppba_pkg.sv
package ppba_pkg;
	localparam int NUM_PAGES_DEF = 65536;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS = 64;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 17;
	localparam int NEED_W = 18;
	localparam logic [15:0] START_RST = 16'd512;
	localparam logic [16:0] END_RST = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END = 1'd1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	localparam logic [0:0] MODE_ALLOC = 1'b0;
	localparam logic [0:0] MODE_FREE = 1'b1;

	function automatic logic [63:0] range_mask(input logic [6:0] lo, input logic [6:0] hi);
		logic [63:0] m_hi;
		logic [63:0] m_lo;
		m_hi = (hi == 7'd64) ? {64{1'b1}} : ~({64{1'b1}} << hi);
		m_lo = {64{1'b1}} << lo;
		return m_hi & m_lo;
	endfunction

	function automatic logic [6:0] low_set(input logic [63:0] x);
		logic [6:0] r;
		r = 7'd64;
		for (int i = 63; i >= 0; i--) begin
			if (x[i]) r = 7'(i);
		end
		return r;
	endfunction

	function automatic logic [6:0] leading_ones(input logic [63:0] x);
		logic [6:0] h;
		logic hit;
		h = 7'd0;
		hit = 1'b0;
		for (int i = 0; i < 64; i++) begin
			if (!x[i]) begin
				h = 7'(i);
				hit = 1'b1;
			end
		end
		return hit ? 7'(7'd63 - h) : 7'd64;
	endfunction

	function automatic logic [63:0] run_hits(input logic [63:0] free, input logic [63:0] carry,
			input logic [6:0] n);
		logic [127:0] r [0:6];
		logic [127:0] acc;
		logic [6:0] off;
		r[0] = {free, carry};
		for (int k = 0; k < 6; k++) begin
			r[k+1] = r[k] & (r[k] << (1 << k));
		end
		acc = {128{1'b1}};
		off = 7'd0;
		for (int b = 0; b < 7; b++) begin
			if (n[b]) begin
				acc = acc & (r[b] << off);
				off = 7'(off + 7'(1 << b));
			end
		end
		return acc[127:64];
	endfunction
endpackage

FILE: design/ppba_ram.sv
module ppba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

FILE: design/physical_page_bitmap_allocator_unit.sv
// First-fit allocator of 4 KiB physical pages over a one-bit-per-page claim map.
// Input channel s_*: s_tuser is the mode (0 allocate, 1 free); s_tdata holds the
// byte count and, for free, the byte address of the first page.
// Output channel m_*: one beat per request; m_tuser is the status, m_tdata holds
// the run address and the count of pages in use after the request.
// Configuration: cfg_we writes cfg_data to the register named by cfg_index
// (0 search start page, 1 search end page) in the same clock edge.
// The claim map lives in one RAM of 64-bit words with a registered read port.
// Allocate scans one word per cycle from the start page word upward, then
// sets the claimed bits one word per cycle.
// Free reads and rewrites one word per cycle.
// Zero-size requests and empty windows skip the map and go straight to S_DONE.
// After reset the RAM is swept to all free, one word per cycle over all DEPTH
// words (1024 by default), while s_tready stays low.
// A result waits in the output register while m_tready is low; the next
// request is accepted meanwhile and stalls only when its own result is ready.
module physical_page_bitmap_allocator_unit #(
	parameter int NUM_PAGES = ppba_pkg::NUM_PAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ppba_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppba_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [63:0] s_tdata, // byte_count[28:0], page_address[56:29], zero fill
	input logic [0:0] s_tuser, // mode[0]
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata, // run_address[27:0], pages_in_use[44:28], zero fill
	output logic [1:0] m_tuser // status[1:0]
);
	import ppba_pkg::*;

	localparam int DEPTH = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = (($clog2(NUM_PAGES) > 17) ? $clog2(NUM_PAGES) : 17) + 2;
	localparam int WW = PW - 6;

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_RMW = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] clr_q;
	logic [15:0] start_q;
	logic [16:0] end_q;
	logic mode_q;
	logic [NEED_W-1:0] need_q;
	logic [PW-1:0] base_q;
	logic [PW-1:0] endp_q;
	logic [WW-1:0] next_w_q;
	logic [WW-1:0] last_w_q;
	logic beyond_q;
	logic [NEED_W-1:0] run_len_q;
	logic [PW-1:0] run_start_q;
	logic [16:0] count_q;
	logic [1:0] status_q;
	logic [27:0] addr_q;
	logic m_valid_q;
	logic [1:0] m_status_q;
	logic [27:0] m_addr_q;
	logic [16:0] m_count_q;
	logic pend_s1;
	logic [WW-1:0] w_s1;

	logic [63:0] rd_data;
	logic rd_en;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0] wr_data;

	logic [28:0] in_bytes;
	logic [NEED_W-1:0] in_need;
	logic [15:0] in_page;
	logic [PW-1:0] endc;
	logic [PW-1:0] fr_endp;
	logic [WW-1:0] fr_lastw;

	logic [PW-1:0] pg0;
	logic [6:0] lo;
	logic [6:0] hi;
	logic [63:0] mask;
	logic [63:0] freew;
	logic [6:0] c_in;
	logic [63:0] carry;
	logic [63:0] hits;
	logic [6:0] hit_e;
	logic [6:0] pre;
	logic [6:0] top;
	logic need_small;
	logic found;
	logic [PW-1:0] found_start;
	logic [PW-1:0] found_end;
	logic [63:0] unclaimed;
	logic [6:0] f_pos;
	logic ferr;
	logic stop;
	logic accept;
	logic out_free;

	assign in_bytes = s_tdata[28:0];
	assign in_need = NEED_W'((30'(in_bytes) + 30'd4095) >> PAGE_SHIFT);
	assign in_page = s_tdata[56:41];
	assign endc = (PW'(end_q) > PW'(NUM_PAGES)) ? PW'(NUM_PAGES) : PW'(end_q);
	assign fr_endp = PW'(in_page) + PW'(in_need);
	assign fr_lastw = WW'((fr_endp - PW'(1)) >> 6);

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign pg0 = {w_s1, 6'd0};
	assign lo = (w_s1 == WW'(base_q >> 6)) ? {1'b0, base_q[5:0]} : 7'd0;
	assign hi = (w_s1 == WW'(endp_q >> 6)) ? {1'b0, endp_q[5:0]} : 7'd64;
	assign mask = range_mask(lo, hi);
	assign freew = ~rd_data & mask;
	assign c_in = (run_len_q >= NEED_W'(64)) ? 7'd64 : run_len_q[6:0];
	assign carry = ~({64{1'b1}} >> c_in);
	assign need_small = (need_q <= NEED_W'(64));
	assign hits = run_hits(freew, carry, need_q[6:0]);
	assign hit_e = low_set(hits);
	assign pre = low_set(~freew);
	assign top = leading_ones(freew);

	always_comb begin
		found = 1'b0;
		found_start = run_start_q;
		if (need_small) begin
			found = (hits != 64'd0);
			found_start = pg0 + PW'(hit_e) + PW'(1) - PW'(need_q[6:0]);
		end else if ((NEED_W+1)'(run_len_q) + (NEED_W+1)'(pre) >= (NEED_W+1)'(need_q)) begin
			found = 1'b1;
			found_start = (run_len_q == '0) ? pg0 : run_start_q;
		end
	end
	assign found_end = found_start + PW'(need_q);

	assign unclaimed = ~rd_data & mask;
	assign ferr = (unclaimed != 64'd0);
	assign f_pos = ferr ? low_set(unclaimed) : hi;

	always_comb begin
		stop = 1'b0;
		if (pend_s1 && state_q == S_SCAN) stop = found || (w_s1 == last_w_q);
		if (pend_s1 && state_q == S_RMW) stop = (mode_q && ferr) || (w_s1 == last_w_q);
	end
	assign rd_en = (state_q == S_SCAN || state_q == S_RMW) && (next_w_q <= last_w_q) && !stop;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = w_s1[AW-1:0];
		wr_data = rd_data | mask;
		if (state_q == S_CLR) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = 64'd0;
		end else if (state_q == S_RMW && pend_s1) begin
			wr_en = 1'b1;
			if (mode_q) wr_data = rd_data & ~range_mask(lo, f_pos);
		end
	end

	ppba_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_map (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(next_w_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			end_q <= END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START: start_q <= cfg_data[15:0];
				CFG_END: end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			count_q <= '0;
			pend_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (rd_en) next_w_q <= next_w_q + WW'(1);
			w_s1 <= next_w_q;
			if (m_valid_q && m_tready && state_q != S_DONE) m_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						mode_q <= s_tuser[0];
						need_q <= in_need;
						addr_q <= 28'd0;
						beyond_q <= 1'b0;
						run_len_q <= '0;
						run_start_q <= '0;
						if (s_tuser[0] == MODE_ALLOC) begin
							base_q <= PW'(start_q);
							endp_q <= endc;
							next_w_q <= WW'(start_q >> 6);
							last_w_q <= WW'((endc - PW'(1)) >> 6);
							if (in_need == '0 || PW'(start_q) >= endc) begin
								status_q <= ST_NOFIT;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							base_q <= PW'(in_page);
							endp_q <= fr_endp;
							next_w_q <= WW'(in_page >> 6);
							last_w_q <= (fr_lastw >= WW'(DEPTH)) ? WW'(DEPTH - 1) : fr_lastw;
							beyond_q <= (fr_lastw >= WW'(DEPTH));
							if (in_need == '0) begin
								status_q <= ST_OK;
								state_q <= S_DONE;
							end else if (WW'(in_page >> 6) >= WW'(DEPTH)) begin
								status_q <= ST_BADFREE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_RMW;
							end
						end
					end
				end
				S_SCAN: begin
					if (pend_s1) begin
						if (found) begin
							base_q <= found_start;
							endp_q <= found_end;
							next_w_q <= WW'(found_start >> 6);
							last_w_q <= WW'((found_end - PW'(1)) >> 6);
							count_q <= count_q + need_q[16:0];
							addr_q <= {found_start[15:0], 12'd0};
							status_q <= ST_OK;
							state_q <= S_RMW;
						end else if (w_s1 == last_w_q) begin
							status_q <= ST_NOFIT;
							state_q <= S_DONE;
						end else if (freew == {64{1'b1}}) begin
							run_len_q <= run_len_q + NEED_W'(64);
							if (run_len_q == '0) run_start_q <= pg0;
						end else begin
							run_len_q <= NEED_W'(top);
							run_start_q <= pg0 + PW'(64) - PW'(top);
						end
					end
				end
				S_RMW: begin
					if (pend_s1) begin
						if (mode_q) count_q <= count_q - 17'(f_pos - lo);
						if (mode_q && ferr) begin
							status_q <= ST_BADFREE;
							state_q <= S_DONE;
						end else if (w_s1 == last_w_q) begin
							status_q <= (mode_q && beyond_q) ? ST_BADFREE : ST_OK;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_status_q <= status_q;
						m_addr_q <= addr_q;
						m_count_q <= count_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser = m_status_q;
	assign m_tdata = {3'd0, m_count_q, m_addr_q};
endmodule

FILE: design/ppba_checker.sv
`include "physical_page_bitmap_allocator_unit_defines.svh"

module ppba_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0] m_tuser
);
	import ppba_pkg::*;

	`PPBA_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
	`PPBA_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
	`PPBA_ASSERT_NOW(a_status_code, m_tvalid, m_tuser == ST_OK || m_tuser == ST_NOFIT || m_tuser == ST_BADFREE, "bad status code")
	`PPBA_ASSERT_NOW(a_fail_addr, m_tvalid && m_tuser != ST_OK, m_tdata[27:0] == 28'd0, "failed request carries an address")
	`PPBA_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken while busy")
endmodule

bind physical_page_bitmap_allocator_unit ppba_checker u_ppba_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ppba_pkg::*;

	localparam int PAGES = 65536;
	localparam longint CYCLE_LIMIT = 10000000;

	typedef struct packed {
		logic [1:0] status;
		logic [27:0] run_address;
		logic [16:0] pages_in_use;
	} alloc_result_t;

	typedef struct {
		int unsigned base_pg;
		int unsigned n_pages;
	} page_run_t;

	typedef enum logic [1:0] {ROW_REQ, ROW_REQ_KNOWN, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e kind;
		logic [0:0] mode;
		logic [28:0] byte_count;
		logic [27:0] page_address;
		alloc_result_t known;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic [1:0] m_tuser;

	physical_page_bitmap_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	bit page_claimed [0:PAGES-1];
	int unsigned claimed_total;
	int unsigned win_start;
	int unsigned win_end;
	page_run_t live_runs [$];
	alloc_result_t pending_results [$];
	int errors;
	bit no_idle;
	longint cycle_count = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic alloc_result_t predict_request(input logic [0:0] mode,
			input logic [28:0] byte_count, input logic [27:0] page_address);
		alloc_result_t r;
		int unsigned need;
		int unsigned hi;
		int unsigned p;
		int unsigned run_first;
		int unsigned run_len;
		bit found;
		page_run_t rec;
		need = (int'(byte_count) + 4095) >> 12;
		r.status = ST_OK;
		r.run_address = '0;
		if (mode == MODE_ALLOC) begin
			hi = (win_end > PAGES) ? PAGES : win_end;
			found = 1'b0;
			run_first = 0;
			run_len = 0;
			if (need != 0) begin
				for (p = win_start; p < hi; p++) begin
					if (page_claimed[p]) begin
						run_len = 0;
					end else begin
						if (run_len == 0) run_first = p;
						run_len++;
						if (run_len == need) begin
							found = 1'b1;
							break;
						end
					end
				end
			end
			if (found) begin
				for (p = run_first; p < run_first + need; p++) page_claimed[p] = 1'b1;
				claimed_total += need;
				r.run_address = 28'(run_first << 12);
				rec.base_pg = run_first;
				rec.n_pages = need;
				live_runs.push_back(rec);
			end else begin
				r.status = ST_NOFIT;
			end
		end else begin
			p = page_address >> 12;
			while (need > 0) begin
				if (p >= PAGES || !page_claimed[p]) begin
					r.status = ST_BADFREE;
					break;
				end
				page_claimed[p] = 1'b0;
				claimed_total--;
				p++;
				need--;
			end
		end
		r.pages_in_use = 17'(claimed_total);
		return r;
	endfunction

	task automatic send_request(input logic [0:0] mode, input logic [28:0] byte_count,
			input logic [27:0] page_address, input bit use_known, input alloc_result_t known);
		alloc_result_t r;
		if (!no_idle && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'd0, page_address, byte_count};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = predict_request(mode, byte_count, page_address);
		pending_results.push_back(use_known ? known : r);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START) win_start = value[15:0];
		else win_end = value;
	endtask

	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		m_tready <= no_idle || ($urandom_range(0, 99) >= 19);
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.run_address = m_tdata[27:0];
			got.pages_in_use = m_tdata[44:28];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat status=%0d addr=%h used=%0d", $time,
					got.status, got.run_address, got.pages_in_use);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
					errors++;
				end
				if (got.run_address !== want.run_address) begin
					$display("%0t: run_address expected %h actual %h", $time,
						want.run_address, got.run_address);
					errors++;
				end
				if (got.pages_in_use !== want.pages_in_use) begin
					$display("%0t: pages_in_use expected %0d actual %0d", $time,
						want.pages_in_use, got.pages_in_use);
					errors++;
				end
			end
		end
	end

	function automatic alloc_result_t res(input logic [1:0] st, input logic [27:0] a,
			input logic [16:0] n);
		alloc_result_t r;
		r.status = st;
		r.run_address = a;
		r.pages_in_use = n;
		return r;
	endfunction

	task automatic random_phase(input int n_items);
		int pick;
		int idx;
		logic [28:0] nbytes;
		page_run_t rec;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				nbytes = 29'($urandom_range(1, 48) * 4096 - $urandom_range(0, 4095));
				send_request(MODE_ALLOC, nbytes, 28'($urandom), 1'b0, '0);
			end else if (pick < 80 && live_runs.size() != 0) begin
				idx = $urandom_range(0, live_runs.size() - 1);
				rec = live_runs[idx];
				live_runs.delete(idx);
				nbytes = 29'(rec.n_pages * 4096 - $urandom_range(0, 4095));
				if ($urandom_range(0, 9) == 0) nbytes = nbytes + 29'd8192;
				send_request(MODE_FREE, nbytes,
					28'((rec.base_pg << 12) | $urandom_range(0, 4095)), 1'b0, '0);
			end else begin
				send_request(1'($urandom), 29'($urandom), 28'($urandom), 1'b0, '0);
			end
		end
	endtask

	stim_row_t directed [$];

	initial begin
		int lo;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_START;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_ALLOC;
		m_tready = 1'b0;
		errors = 0;
		no_idle = 1'b0;
		claimed_total = 0;
		win_start = 512;
		win_end = 65536;
		foreach (page_claimed[i]) page_claimed[i] = 1'b0;

		directed = '{
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'd0, 28'd0, res(ST_NOFIT, 28'd0, 17'd0)},
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'd1, 28'hFFFFFFF, res(ST_OK, 28'h200000, 17'd1)},
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'd4096, 28'd0, res(ST_OK, 28'h201000, 17'd2)},
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'd4097, 28'd0, res(ST_OK, 28'h202000, 17'd4)},
			'{ROW_REQ_KNOWN, MODE_FREE, 29'd0, 28'h200000, res(ST_OK, 28'd0, 17'd4)},
			'{ROW_REQ_KNOWN, MODE_FREE, 29'd4096, 28'h200FFF, res(ST_OK, 28'd0, 17'd3)},
			'{ROW_REQ_KNOWN, MODE_FREE, 29'd4096, 28'h200000,
				res(ST_BADFREE, 28'd0, 17'd3)},
			'{ROW_REQ_KNOWN, MODE_FREE, 29'd12288, 28'h201000, res(ST_OK, 28'd0, 17'd0)},
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'h10000000, 28'd0, res(ST_NOFIT, 28'd0, 17'd0)},
			'{ROW_REQ_KNOWN, MODE_FREE, 29'h10000000, 28'hFFFFFFF,
				res(ST_BADFREE, 28'd0, 17'd0)},
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'hFE00000, 28'd0,
				res(ST_OK, 28'h200000, 17'd65024)},
			'{ROW_REQ_KNOWN, MODE_FREE, 29'h1FFFFFFF, 28'h200000,
				res(ST_BADFREE, 28'd0, 17'd0)},
			'{ROW_CFG, CFG_START, 29'd0, 28'd0, '0},
			'{ROW_CFG, CFG_END, 29'h1FFFF, 28'd0, '0},
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'd1, 28'd0, res(ST_OK, 28'd0, 17'd1)},
			'{ROW_REQ_KNOWN, MODE_ALLOC, 29'd4096, 28'd0, res(ST_OK, 28'h1000, 17'd2)},
			'{ROW_REQ, MODE_ALLOC, 29'd40000, 28'd0, '0},
			'{ROW_REQ, MODE_FREE, 29'd8192, 28'd0, '0},
			'{ROW_CFG, CFG_START, 29'd5, 28'd0, '0},
			'{ROW_CFG, CFG_END, 29'd5, 28'd0, '0},
			'{ROW_REQ, MODE_ALLOC, 29'd4096, 28'd0, '0},
			'{ROW_CFG, CFG_END, 29'd4, 28'd0, '0},
			'{ROW_REQ, MODE_ALLOC, 29'd4096, 28'd0, '0},
			'{ROW_CFG, CFG_START, 29'hFFFF, 28'd0, '0},
			'{ROW_CFG, CFG_END, 29'h10000, 28'd0, '0},
			'{ROW_REQ, MODE_ALLOC, 29'd4096, 28'd0, '0},
			'{ROW_REQ, MODE_ALLOC, 29'd4096, 28'd0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_register(directed[i].mode, directed[i].byte_count[16:0]);
			else
				send_request(directed[i].mode, directed[i].byte_count,
					directed[i].page_address, directed[i].kind == ROW_REQ_KNOWN,
					directed[i].known);
		end

		write_register(CFG_START, 17'd0);
		write_register(CFG_END, 17'd300);
		random_phase(90);
		write_register(CFG_START, 17'd1000);
		write_register(CFG_END, 17'd1300);
		no_idle = 1'b1;
		random_phase(90);
		no_idle = 1'b0;
		write_register(CFG_START, 17'd65535);
		write_register(CFG_END, 17'd65536);
		random_phase(40);
		write_register(CFG_START, 17'd512);
		write_register(CFG_END, 17'd65536);
		random_phase(90);
		lo = $urandom_range(0, 60000);
		write_register(CFG_START, 17'(lo));
		write_register(CFG_END, 17'(lo + $urandom_range(64, 512)));
		random_phase(90);
		write_register(CFG_START, 17'd1);
		write_register(CFG_END, 17'h1FFFF);
		random_phase(90);
		write_register(CFG_START, 17'd3);
		write_register(CFG_END, 17'd200);
		random_phase(50);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
